>>> rtl/wffla_pkg.sv
// shared types and constants for the worst-fit free list allocator
// no dependencies
package wffla_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OFF_W       = 31;
  localparam int SIZE_W      = 15;
  localparam int LEFT_W      = SIZE_W + 2;

  localparam logic [SIZE_W-1:0] SPLIT_RESET = SIZE_W'(10);
  localparam logic [SIZE_W-1:0] HDR_BYTES   = SIZE_W'(2);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_FREED     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_POP_RD,
    S_POP_WR,
    S_INS_RD,
    S_INS_CHK,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

>>> rtl/worst_fit_free_list_allocator_core.sv
// worst-fit free list allocator: sorted region table in a small memory, walked by a sequencer
// depends on wffla_pkg
//
// channel | handshake               | payload
// --------+-------------------------+---------------------------------------------------
// in      | start, busy             | in_opcode, in_record_length, in_region_offset, in_region_size
// out     | out_valid (one cycle)   | out_status, out_grant_*, out_leftover_*, out_free_count
// cfg     | cfg_we                  | cfg_data (split threshold)
//
// one transaction at a time; busy is high from acceptance through the result cycle
// each table step is a read, then a compare and write, on the one memory port pair
// an allocate on an empty table, or whose head is too small, ends without walking the table;
// otherwise the head is popped, the rest shifted up, and a split reinserts the remainder;
// a free inserts in size order; the sequencer passes back through idle before the next acceptance
// rst_n is synchronous; it empties the table and sets the threshold to 10
// the receiver cannot stall; the result is shown for exactly one cycle
module worst_fit_free_list_allocator_core
  import wffla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [SIZE_W-1:0] in_record_length,
  input  logic [OFF_W-1:0]  in_region_offset,
  input  logic [SIZE_W-1:0] in_region_size,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [OFF_W-1:0]  out_grant_offset,
  output logic [SIZE_W-1:0] out_grant_size,
  output logic [OFF_W-1:0]  out_leftover_offset,
  output logic [SIZE_W-1:0] out_leftover_size,
  output logic [CNT_W-1:0]  out_free_count,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_r;

  fsm_t              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [SIZE_W-1:0] thr_r;
  logic [SIZE_W-1:0] len_r, len_nxt;
  logic [OFF_W-1:0]  ins_off_r, ins_off_nxt;
  logic [SIZE_W-1:0] ins_size_r, ins_size_nxt;
  logic              split_r, split_nxt;
  status_t           status_r, status_nxt;
  logic [OFF_W-1:0]  goff_r, goff_nxt;
  logic [SIZE_W-1:0] gsize_r, gsize_nxt;
  logic [OFF_W-1:0]  loff_r, loff_nxt;
  logic [SIZE_W-1:0] lsize_r, lsize_nxt;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  logic [LEFT_W-1:0] left;
  logic [CNT_W-1:0]  k_dec;

  assign left  = {2'b00, rd_r.size} - {2'b00, len_r} - {2'b00, HDR_BYTES};
  assign k_dec = k_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      thr_r   <= SPLIT_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    len_r      <= len_nxt;
    ins_off_r  <= ins_off_nxt;
    ins_size_r <= ins_size_nxt;
    split_r    <= split_nxt;
    status_r   <= status_nxt;
    goff_r     <= goff_nxt;
    gsize_r    <= gsize_nxt;
    loff_r     <= loff_nxt;
    lsize_r    <= lsize_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    k_nxt        = k_r;
    len_nxt      = len_r;
    ins_off_nxt  = ins_off_r;
    ins_size_nxt = ins_size_r;
    split_nxt    = split_r;
    status_nxt   = status_r;
    goff_nxt     = goff_r;
    gsize_nxt    = gsize_r;
    loff_nxt     = loff_r;
    lsize_nxt    = lsize_r;
    mem_we       = 1'b0;
    mem_waddr    = k_r[IDX_W-1:0];
    mem_wdata    = rd_r;
    mem_raddr    = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          len_nxt      = in_record_length;
          ins_off_nxt  = in_region_offset;
          ins_size_nxt = in_region_size;
          split_nxt    = 1'b0;
          goff_nxt     = '0;
          gsize_nxt    = '0;
          loff_nxt     = '0;
          lsize_nxt    = '0;
          k_nxt        = count_r;
          if (opcode_t'(in_opcode) == OP_ALLOC) begin
            if (count_r == '0) begin
              status_nxt = ST_NO_FIT;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_HEAD_RD;
            end
          end else begin
            if (count_r >= CNT_W'(TABLE_DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              status_nxt = ST_FREED;
              state_nxt  = S_INS_RD;
            end
          end
        end
      end

      S_HEAD_RD: begin
        mem_raddr = '0;
        state_nxt = S_HEAD_CHK;
      end

      S_HEAD_CHK: begin
        if (rd_r.size < len_r) begin
          status_nxt = ST_NO_FIT;
          state_nxt  = S_DONE;
        end else begin
          status_nxt = ST_ALLOCATED;
          goff_nxt   = rd_r.off;
          k_nxt      = CNT_W'(1);
          state_nxt  = S_POP_RD;
          if ($signed(left) > $signed({2'b00, thr_r})) begin
            split_nxt    = 1'b1;
            gsize_nxt    = len_r;
            ins_off_nxt  = rd_r.off + {{(OFF_W-SIZE_W){1'b0}}, len_r}
                           + {{(OFF_W-SIZE_W){1'b0}}, HDR_BYTES};
            ins_size_nxt = left[SIZE_W-1:0];
            loff_nxt     = ins_off_nxt;
            lsize_nxt    = left[SIZE_W-1:0];
          end else begin
            gsize_nxt = rd_r.size;
          end
        end
      end

      S_POP_RD: begin
        mem_raddr = k_r[IDX_W-1:0];
        if (k_r >= count_r) begin
          count_nxt = count_r - CNT_W'(1);
          k_nxt     = count_r - CNT_W'(1);
          state_nxt = split_r ? S_INS_RD : S_DONE;
        end else begin
          state_nxt = S_POP_WR;
        end
      end

      S_POP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_dec[IDX_W-1:0];
        mem_wdata = rd_r;
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = S_POP_RD;
      end

      S_INS_RD: begin
        mem_raddr = k_dec[IDX_W-1:0];
        if (k_r == '0) begin
          mem_we         = 1'b1;
          mem_waddr      = '0;
          mem_wdata.off  = ins_off_r;
          mem_wdata.size = ins_size_r;
          count_nxt      = count_r + CNT_W'(1);
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[IDX_W-1:0];
        if (rd_r.size >= ins_size_r) begin
          mem_wdata.off  = ins_off_r;
          mem_wdata.size = ins_size_r;
          count_nxt      = count_r + CNT_W'(1);
          state_nxt      = S_DONE;
        end else begin
          mem_wdata = rd_r;
          k_nxt     = k_dec;
          state_nxt = S_INS_RD;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_DONE);
  assign out_status          = status_r;
  assign out_grant_offset    = goff_r;
  assign out_grant_size      = gsize_r;
  assign out_leftover_offset = loff_r;
  assign out_leftover_size   = lsize_r;
  assign out_free_count      = count_r;

endmodule

>>> verif/tb_top.sv
// self-checking testbench for worst_fit_free_list_allocator_core: directed corner cases, then
// random allocate/free traffic under several split thresholds, checked against an in-bench table
// depends on wffla_pkg and the allocator core
module tb_top;
  import wffla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    opcode_t           op;
    logic [SIZE_W-1:0] len;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } request_t;

  typedef struct {
    status_t           st;
    logic [OFF_W-1:0]  goff;
    logic [SIZE_W-1:0] gsize;
    logic [OFF_W-1:0]  loff;
    logic [SIZE_W-1:0] lsize;
    logic [CNT_W-1:0]  cnt;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              in_opcode = 1'b0;
  logic [SIZE_W-1:0] in_record_length = '0;
  logic [OFF_W-1:0]  in_region_offset = '0;
  logic [SIZE_W-1:0] in_region_size = '0;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic              busy;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [OFF_W-1:0]  out_grant_offset;
  logic [SIZE_W-1:0] out_grant_size;
  logic [OFF_W-1:0]  out_leftover_offset;
  logic [SIZE_W-1:0] out_leftover_size;
  logic [CNT_W-1:0]  out_free_count;

  worst_fit_free_list_allocator_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_record_length    (in_record_length),
    .in_region_offset    (in_region_offset),
    .in_region_size      (in_region_size),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_grant_offset    (out_grant_offset),
    .out_grant_size      (out_grant_size),
    .out_leftover_offset (out_leftover_offset),
    .out_leftover_size   (out_leftover_size),
    .out_free_count      (out_free_count),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // free region table kept by the bench
  entry_t            free_tab[TABLE_DEPTH];
  int unsigned       free_n = 0;
  logic [SIZE_W-1:0] split_thr = SPLIT_RESET;

  request_t request_q[$];
  outcome_t outcome_q[$];
  request_t cur_req;
  bit       req_live = 1'b0;
  int       burst_left = 1;
  int       gap_left = 0;

  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned grant_cnt = 0;
  int unsigned split_cnt = 0;
  int unsigned nofit_cnt = 0;
  int unsigned freed_cnt = 0;
  int unsigned dropped_cnt = 0;
  logic [SIZE_W-1:0] thr_mid;

  function automatic void table_insert(logic [OFF_W-1:0] off, logic [SIZE_W-1:0] size);
    int unsigned pos;
    int unsigned k;
    pos = 0;
    if (free_n >= TABLE_DEPTH) return;
    while (pos < free_n && free_tab[pos].size >= size) pos++;
    for (k = free_n; k > pos; k--) free_tab[k] = free_tab[k-1];
    free_tab[pos].off = off;
    free_tab[pos].size = size;
    free_n++;
  endfunction

  function automatic outcome_t worst_fit_apply(request_t r);
    outcome_t    o;
    entry_t      head;
    int          left;
    int unsigned k;
    o.st = ST_NO_FIT;
    o.goff = '0;
    o.gsize = '0;
    o.loff = '0;
    o.lsize = '0;
    if (r.op == OP_ALLOC) begin
      if (free_n == 0 || free_tab[0].size < r.len) begin
        nofit_cnt++;
      end else begin
        head = free_tab[0];
        left = int'(head.size) - int'(r.len) - int'(HDR_BYTES);
        for (k = 1; k < free_n; k++) free_tab[k-1] = free_tab[k];
        free_n--;
        o.st = ST_ALLOCATED;
        o.goff = head.off;
        grant_cnt++;
        if (left > int'(split_thr)) begin
          o.gsize = r.len;
          o.loff = head.off + OFF_W'(r.len) + OFF_W'(HDR_BYTES);
          o.lsize = SIZE_W'(left);
          table_insert(o.loff, o.lsize);
          split_cnt++;
        end else begin
          o.gsize = head.size;
        end
      end
    end else if (free_n >= TABLE_DEPTH) begin
      o.st = ST_FULL;
      dropped_cnt++;
    end else begin
      table_insert(r.off, r.size);
      o.st = ST_FREED;
      freed_cnt++;
    end
    o.cnt = CNT_W'(free_n);
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] mismatch on result %0d: %s", $time, checked_cnt, msg);
  endtask

  // driver: bursts of transactions with random gaps between them
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(worst_fit_apply(cur_req));
        req_live = 1'b0;
      end
      if (!req_live) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          req_live = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end
          in_opcode <= cur_req.op;
          in_record_length <= cur_req.len;
          in_region_offset <= cur_req.off;
          in_region_size <= cur_req.size;
        end
      end
      start <= req_live;
    end
  end

  // monitor: one result per strobe, never held off
  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = outcome_q.pop_front();
        if (out_status !== want.st)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.st));
        if (out_grant_offset !== want.goff)
          report_mismatch($sformatf("grant_offset got %h want %h", out_grant_offset, want.goff));
        if (out_grant_size !== want.gsize)
          report_mismatch($sformatf("grant_size got %0d want %0d", out_grant_size, want.gsize));
        if (out_leftover_offset !== want.loff)
          report_mismatch($sformatf("leftover_offset got %h want %h", out_leftover_offset,
                                    want.loff));
        if (out_leftover_size !== want.lsize)
          report_mismatch($sformatf("leftover_size got %0d want %0d", out_leftover_size,
                                    want.lsize));
        if (out_free_count !== want.cnt)
          report_mismatch($sformatf("free_count got %0d want %0d", out_free_count, want.cnt));
      end
      checked_cnt++;
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, outcome_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [SIZE_W-1:0] rand_size(int small_bias);
    int r;
    r = $urandom_range(0, 9);
    if (r < small_bias) return SIZE_W'($urandom_range(0, 48));
    if (r < 9) return SIZE_W'($urandom_range(0, 3000));
    return SIZE_W'($urandom);
  endfunction

  function automatic logic [OFF_W-1:0] rand_offset();
    if ($urandom_range(0, 4) == 0) return OFF_W'(32'h7FFF_FFFF - $urandom_range(0, 40000));
    return OFF_W'($urandom);
  endfunction

  task automatic add_alloc(input logic [SIZE_W-1:0] len);
    request_t r;
    r.op = OP_ALLOC;
    r.len = len;
    r.off = OFF_W'($urandom);
    r.size = SIZE_W'($urandom);
    request_q.push_back(r);
  endtask

  task automatic add_free(input logic [OFF_W-1:0] off, input logic [SIZE_W-1:0] size);
    request_t r;
    r.op = OP_FREE;
    r.len = SIZE_W'($urandom);
    r.off = off;
    r.size = size;
    request_q.push_back(r);
  endtask

  task automatic drain();
    while (request_q.size() != 0 || req_live || outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [SIZE_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    split_thr = v;
  endtask

  task automatic run_mix(int n, int free_pct, int small_bias);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, 100) <= free_pct) add_free(rand_offset(), rand_size(small_bias));
      else add_alloc(rand_size(small_bias));
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, zero size, wrap of the remainder offset, threshold boundary, full table
    add_alloc(SIZE_W'(0));
    add_free(OFF_W'(0), SIZE_W'(0));
    add_alloc(SIZE_W'(0));
    add_free(OFF_W'(32'h7FFF_FFF0), SIZE_W'(32767));
    add_free(OFF_W'(100), SIZE_W'(12));
    add_free(OFF_W'(200), SIZE_W'(12));
    add_alloc(SIZE_W'(100));
    add_alloc(SIZE_W'(32663));
    add_alloc(SIZE_W'(0));
    add_alloc(SIZE_W'(32767));
    for (int k = 0; k < 15; k++)
      add_free((k == 14) ? OFF_W'(32'h7FFF_FFFF) : OFF_W'(k * 1000), SIZE_W'((k * 37) % 60));
    add_free(rand_offset(), SIZE_W'(32767));
    drain();

    set_threshold(SIZE_W'(0));
    run_mix(450, 55, 6);
    set_threshold(SIZE_W'(32767));
    run_mix(300, 50, 3);
    thr_mid = SIZE_W'($urandom_range(1, 500));
    set_threshold(thr_mid);
    run_mix(500, 70, 4);
    set_threshold(SPLIT_RESET);
    run_mix(480, 35, 5);

    $display("covered %0d transactions: %0d granted (%0d split), %0d no fit, %0d freed, %0d dropped",
             checked_cnt, grant_cnt, split_cnt, nofit_cnt, freed_cnt, dropped_cnt);
    $display("split thresholds used: %0d, 0, 32767, %0d, %0d", SPLIT_RESET, thr_mid, SPLIT_RESET);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
